/* rtl/csa_pkg.sv */
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants for the compacting slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int SLOTS   = 32;
  localparam int DEVICES = 32;
  localparam int ID_W    = 5;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int OCC_W   = 6;
  localparam int OCC_MAX = (1 << OCC_W) - 1;

  typedef enum logic [1:0] {
    CMD_CONNECT     = 2'd0,
    CMD_DEV_OF_SLOT = 2'd1,
    CMD_SLOT_OF_DEV = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic            changed;
    logic            found;
    logic [ID_W-1:0] result_id;
    logic            moved;
    logic [ID_W-1:0] moved_device;
    logic [ID_W-1:0] moved_to_slot;
  } result_t;

  function automatic logic [OCC_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    logic [OCC_W-1:0] r;
    if (int'(n) > OCC_MAX) r = OCC_W'(OCC_MAX);
    else                   r = OCC_W'(n);
    return r;
  endfunction

endpackage

/* rtl/csa_ram.sv */
// ----------------------------------------------------------------------------
// csa_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/compacting_slot_allocator.sv */
// ----------------------------------------------------------------------------
// compacting_slot_allocator
// Maps device ids to densely packed slots; compacts on disconnect.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   request  in_valid / in_stall    cmd, cube_id, connected
//   result   out_valid / out_stall  changed, found, result_id, moved,
//                                   moved_device, moved_to_slot, occupied_count
//
// A request passes through states IDLE and EXEC: the accept cycle in IDLE reads
// both tables, and EXEC updates them and loads the result register. The tables
// have registered read data, so the update waits for EXEC. A request is taken
// while a result still waits; EXEC holds only while that result is still stalled.
// Reset clears the mapped-device mask and the slot count; the tables need no
// clearing pass.
module compacting_slot_allocator
  import csa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [ID_W-1:0]  cube_id,
  input  logic             connected,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             changed,
  output logic             found,
  output logic [ID_W-1:0]  result_id,
  output logic             moved,
  output logic [ID_W-1:0]  moved_device,
  output logic [ID_W-1:0]  moved_to_slot,
  output logic [OCC_W-1:0] occupied_count
);

  state_t state, state_next;

  logic [1:0]         cmd_q;
  logic [ID_W-1:0]    id_q;
  logic               conn_q;
  logic [DEVICES-1:0] device_mapped, device_mapped_next;
  logic [CNT_W-1:0]   count, count_next;

  logic               accept;
  logic               fire;
  logic               rd_en;
  logic [SLOT_W-1:0]  dos_raddr;
  logic [ID_W-1:0]    dos_rdata;
  logic [SLOT_W-1:0]  sod_rdata;

  logic               dos_we;
  logic [SLOT_W-1:0]  dos_waddr;
  logic [ID_W-1:0]    dos_wdata;
  logic               sod_we;
  logic [ID_W-1:0]    sod_waddr;
  logic [SLOT_W-1:0]  sod_wdata;

  logic               mapped;
  result_t            res;

  assign accept = in_valid && !in_stall;
  assign fire   = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign rd_en  = accept;
  assign mapped = device_mapped[id_q];

  // Slot lookups read the addressed slot; disconnects read the top slot.
  assign dos_raddr = (cmd_t'(cmd) == CMD_DEV_OF_SLOT) ? SLOT_W'(cube_id)
                                                      : SLOT_W'(count - CNT_W'(1));

  csa_ram #(.DEPTH(SLOTS), .WIDTH(ID_W)) u_dev_of_slot (
    .clk   (clk),
    .we    (dos_we),
    .waddr (dos_waddr),
    .wdata (dos_wdata),
    .re    (rd_en),
    .raddr (dos_raddr),
    .rdata (dos_rdata)
  );

  csa_ram #(.DEPTH(DEVICES), .WIDTH(SLOT_W)) u_slot_of_dev (
    .clk   (clk),
    .we    (sod_we),
    .waddr (sod_waddr),
    .wdata (sod_wdata),
    .re    (rd_en),
    .raddr (cube_id),
    .rdata (sod_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      device_mapped <= '0;
      count         <= '0;
    end else begin
      state         <= state_next;
      device_mapped <= device_mapped_next;
      count         <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      id_q   <= cube_id;
      conn_q <= connected;
    end
  end

  always_comb begin
    state_next         = state;
    in_stall           = (state != ST_IDLE);
    device_mapped_next = device_mapped;
    count_next         = count;
    res                = '0;
    dos_we             = 1'b0;
    dos_waddr          = SLOT_W'(count);
    dos_wdata          = id_q;
    sod_we             = 1'b0;
    sod_waddr          = id_q;
    sod_wdata          = SLOT_W'(count);

    case (cmd_t'(cmd_q))
      CMD_CONNECT: begin
        if (conn_q) begin
          if (mapped) begin
            res.found     = 1'b1;
            res.result_id = ID_W'(sod_rdata);
          end else if (count < CNT_W'(SLOTS)) begin
            // Slots stay packed, so the lowest free slot is the count.
            res.changed   = 1'b1;
            res.found     = 1'b1;
            res.result_id = ID_W'(count);
            dos_we        = 1'b1;
            sod_we        = 1'b1;
            device_mapped_next[id_q] = 1'b1;
            count_next    = count + CNT_W'(1);
          end
        end else if (mapped) begin
          res.changed = 1'b1;
          device_mapped_next[id_q] = 1'b0;
          count_next  = count - CNT_W'(1);
          // Move the top slot's device into the hole when the hole is below it.
          if (CNT_W'(sod_rdata) + CNT_W'(1) < count) begin
            res.moved         = 1'b1;
            res.moved_device  = dos_rdata;
            res.moved_to_slot = ID_W'(sod_rdata);
            dos_we            = 1'b1;
            dos_waddr         = sod_rdata;
            dos_wdata         = dos_rdata;
            sod_we            = 1'b1;
            sod_waddr         = dos_rdata;
            sod_wdata         = sod_rdata;
          end
        end
      end
      CMD_DEV_OF_SLOT: begin
        // Occupied slots are packed below the count.
        if (CNT_W'(id_q) < count) begin
          res.found     = 1'b1;
          res.result_id = dos_rdata;
        end
      end
      CMD_SLOT_OF_DEV: begin
        if (mapped) begin
          res.found     = 1'b1;
          res.result_id = ID_W'(sod_rdata);
        end
      end
      default: begin
      end
    endcase

    // Commit only on the cycle the result register takes the result.
    if (!fire) begin
      device_mapped_next = device_mapped;
      count_next         = count;
      dos_we             = 1'b0;
      sod_we             = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      changed        <= res.changed;
      found          <= res.found;
      result_id      <= res.result_id;
      moved          <= res.moved;
      moved_device   <= res.moved_device;
      moved_to_slot  <= res.moved_to_slot;
      occupied_count <= sat_count(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= SLOTS)
    else $error("slot count exceeds table size");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(device_mapped) == int'(count))
    else $error("mapped device mask disagrees with slot count");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter update cycle");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("update cycle produced no result");
`endif

endmodule

/* test/tb_compacting_slot_allocator.sv */
// ----------------------------------------------------------------------------
// tb_compacting_slot_allocator
// Drives connect, disconnect and lookup requests into the slot allocator. A
// local copy of both mapping tables works out each expected result, and every
// result is checked field by field in request order. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_compacting_slot_allocator
  import csa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         LIMIT_CYCLES = 800_000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         MAX_REPORTS  = 50;

  typedef struct packed {
    logic             changed;
    logic             found;
    logic [ID_W-1:0]  result_id;
    logic             moved;
    logic [ID_W-1:0]  moved_device;
    logic [ID_W-1:0]  moved_to_slot;
    logic [OCC_W-1:0] occupied_count;
  } alloc_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       cmd = 2'd0;
  logic [ID_W-1:0]  cube_id = '0;
  logic             connected = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             changed;
  logic             found;
  logic [ID_W-1:0]  result_id;
  logic             moved;
  logic [ID_W-1:0]  moved_device;
  logic [ID_W-1:0]  moved_to_slot;
  logic [OCC_W-1:0] occupied_count;

  // local copy of the mapping
  logic [ID_W-1:0]   device_in_slot [SLOTS];
  logic [SLOT_W-1:0] slot_of_dev    [DEVICES];
  logic [SLOTS-1:0]  slot_used = '0;
  logic [DEVICES-1:0] dev_mapped = '0;

  alloc_result_t owed_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  requests_sent = 0;
  int  results_checked = 0;
  int  moves_seen = 0;
  int  peak_occupancy = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  compacting_slot_allocator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               owed_results.size());
      $display("tb_compacting_slot_allocator: errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic alloc_result_t mapping_step(input logic [1:0] c,
                                                 input logic [ID_W-1:0] id,
                                                 input logic conn);
    alloc_result_t   r;
    int              s;
    int              hole;
    int              h;
    int              n;
    logic [ID_W-1:0] d;
    r = '0;
    case (c)
      CMD_CONNECT: begin
        if (conn) begin
          if (dev_mapped[id]) begin
            r.found     = 1'b1;
            r.result_id = ID_W'(slot_of_dev[id]);
          end else begin
            s = 0;
            while (s < SLOTS && slot_used[s]) s++;
            if (s < SLOTS) begin
              device_in_slot[s] = id;
              slot_of_dev[id]   = SLOT_W'(s);
              slot_used[s]      = 1'b1;
              dev_mapped[id]    = 1'b1;
              r.changed         = 1'b1;
              r.found           = 1'b1;
              r.result_id       = ID_W'(s);
            end
          end
        end else if (dev_mapped[id]) begin
          hole = int'(slot_of_dev[id]);
          dev_mapped[id]  = 1'b0;
          slot_used[hole] = 1'b0;
          r.changed       = 1'b1;
          // pull the highest occupied slot down into the hole
          h = SLOTS - 1;
          while (h > hole && !slot_used[h]) h--;
          if (h > hole) begin
            d = device_in_slot[h];
            slot_used[h]         = 1'b0;
            device_in_slot[hole] = d;
            slot_of_dev[d]       = SLOT_W'(hole);
            slot_used[hole]      = 1'b1;
            r.moved              = 1'b1;
            r.moved_device       = d;
            r.moved_to_slot      = ID_W'(hole);
          end
        end
      end
      CMD_DEV_OF_SLOT: begin
        if (int'(id) < SLOTS && slot_used[id]) begin
          r.found     = 1'b1;
          r.result_id = device_in_slot[id];
        end
      end
      CMD_SLOT_OF_DEV: begin
        if (dev_mapped[id]) begin
          r.found     = 1'b1;
          r.result_id = ID_W'(slot_of_dev[id]);
        end
      end
      default: ;
    endcase
    n = $countones(slot_used);
    r.occupied_count = (n > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(n);
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_mapped_device();
    int start;
    int k;
    start = $urandom_range(0, DEVICES - 1);
    for (k = 0; k < DEVICES; k++)
      if (dev_mapped[(start + k) % DEVICES]) return ID_W'((start + k) % DEVICES);
    return ID_W'(start);
  endfunction

  // present one request, hold it until taken, then record what it must return
  task automatic send_request(input logic [1:0] c, input logic [ID_W-1:0] id,
                              input logic conn);
    int            gap;
    alloc_result_t want;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    cube_id   <= id;
    connected <= conn;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = mapping_step(c, id, conn);
    owed_results.push_back(want);
    requests_sent++;
    if (want.moved) moves_seen++;
    if (int'(want.occupied_count) > peak_occupancy) peak_occupancy = want.occupied_count;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // result side: random stall, check each accepted result against the oldest owed one
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          check_field("changed", want.changed, changed);
          check_field("found", want.found, found);
          check_field("result_id", want.result_id, result_id);
          check_field("moved", want.moved, moved);
          check_field("moved_device", want.moved_device, moved_device);
          check_field("moved_to_slot", want.moved_to_slot, moved_to_slot);
          check_field("occupied_count", want.occupied_count, occupied_count);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_empty_table();
    send_request(CMD_SLOT_OF_DEV, 5'd0, 1'b0);
    send_request(CMD_SLOT_OF_DEV, 5'd31, 1'b1);
    send_request(CMD_DEV_OF_SLOT, 5'd0, 1'b0);
    send_request(CMD_DEV_OF_SLOT, 5'd31, 1'b1);
    // disconnect of a device that was never mapped
    send_request(CMD_CONNECT, 5'd21, 1'b0);
    send_request(CMD_UNUSED, 5'd31, 1'b1);
  endtask

  task automatic test_connect_and_compact();
    send_request(CMD_CONNECT, 5'd31, 1'b1);
    send_request(CMD_CONNECT, 5'd0, 1'b1);
    send_request(CMD_CONNECT, 5'd10, 1'b1);
    // reconnect of a mapped device keeps its slot
    send_request(CMD_CONNECT, 5'd31, 1'b1);
    send_request(CMD_SLOT_OF_DEV, 5'd10, 1'b0);
    send_request(CMD_DEV_OF_SLOT, 5'd2, 1'b0);
    send_request(CMD_CONNECT, 5'd31, 1'b0);
    send_request(CMD_DEV_OF_SLOT, 5'd0, 1'b1);
    send_request(CMD_CONNECT, 5'd10, 1'b0);
    // last occupied slot leaves, nothing to move
    send_request(CMD_CONNECT, 5'd0, 1'b0);
    send_request(CMD_DEV_OF_SLOT, 5'd0, 1'b0);
    send_request(CMD_UNUSED, 5'd0, 1'b0);
  endtask

  task automatic test_fill_drain(input int rounds);
    logic [ID_W-1:0] order [DEVICES];
    logic [ID_W-1:0] t;
    int              i;
    int              j;
    int              k;
    for (k = 0; k < rounds; k++) begin
      steady = (k == 0);
      for (i = 0; i < DEVICES; i++) order[i] = ID_W'(i);
      for (i = DEVICES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (i = 0; i < DEVICES; i++) begin
        send_request(CMD_CONNECT, order[i], 1'b1);
        if (i % 4 == 3) send_request(CMD_DEV_OF_SLOT, ID_W'($urandom_range(0, 31)), 1'b0);
      end
      // every slot taken
      send_request(CMD_DEV_OF_SLOT, 5'd31, 1'b0);
      send_request(CMD_SLOT_OF_DEV, order[0], 1'b1);
      send_request(CMD_CONNECT, order[DEVICES - 1], 1'b1);
      send_request(CMD_UNUSED, ID_W'($urandom_range(0, 31)), 1'b1);
      for (i = DEVICES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (i = 0; i < DEVICES; i++) begin
        send_request(CMD_CONNECT, order[i], 1'b0);
        if (i % 4 == 1) send_request(CMD_SLOT_OF_DEV, ID_W'($urandom_range(0, 31)), 1'b0);
      end
    end
    steady = 1'b0;
  endtask

  task automatic random_request(input int connect_bias);
    int              r;
    int              occ;
    logic [ID_W-1:0] id;
    r   = $urandom_range(0, 99);
    occ = $countones(slot_used);
    id  = ID_W'($urandom_range(0, 31));
    if (r < 55) begin
      if ($urandom_range(0, 99) < connect_bias) begin
        send_request(CMD_CONNECT, id, 1'b1);
      end else begin
        // aim most disconnects at mapped devices so compaction happens
        if ($urandom_range(0, 9) < 7) id = pick_mapped_device();
        send_request(CMD_CONNECT, id, 1'b0);
      end
    end else if (r < 75) begin
      if ($urandom_range(0, 9) < 7) id = ID_W'((occ > 31) ? 31 : $urandom_range(0, occ));
      send_request(CMD_DEV_OF_SLOT, id, 1'($urandom_range(0, 1)));
    end else if (r < 95) begin
      send_request(CMD_SLOT_OF_DEV, id, 1'($urandom_range(0, 1)));
    end else begin
      send_request(CMD_UNUSED, id, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_churn(input int n_items);
    int i;
    int bias;
    bias = 60;
    for (i = 0; i < n_items; i++) begin
      // new idling mode and fill/drain lean every hundred requests
      if (i % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        bias   = $urandom_range(20, 85);
      end
      random_request(bias);
    end
    steady = 1'b0;
  endtask

  task automatic test_pause_for_results(input int bursts, input int per_burst);
    int b;
    int i;
    for (b = 0; b < bursts; b++) begin
      for (i = 0; i < per_burst; i++) random_request(55);
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_connect_and_compact();
    test_fill_drain(2);
    test_pause_for_results(6, 15);
    test_churn(870);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, owed_results.size());
    end

    $display("covered %0d requests and %0d results: %0d compaction moves, peak of %0d slots",
             requests_sent, results_checked, moves_seen, peak_occupancy);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("tb_compacting_slot_allocator: clean");
    end else begin
      $display("tb_compacting_slot_allocator: errors");
    end
    $finish;
  end

endmodule

/* compacting_slot_allocator.f */
rtl/csa_pkg.sv
rtl/csa_ram.sv
rtl/compacting_slot_allocator.sv
test/tb_compacting_slot_allocator.sv
